// ===== design/vtp_pkg.sv =====
package vtp_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned ProdW   = 2 * CoordW;
  localparam int unsigned PairW   = ProdW + 1;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuoW    = CoordW + FracW;
  localparam int unsigned NumLane = 3;
  localparam int unsigned NumStep = QuoW;

  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef logic [NumRegs-1:0][CfgW-1:0] matrix_t;

  // Transformed point, one request handed from the front to the back
  typedef struct packed {
    logic [3:0][CoordW-1:0] r;
    logic                   ovf;
  } xform_t;

  // Finished result
  typedef struct packed {
    logic [3:0][CoordW-1:0] r;
    logic                   div;
    logic                   ovf;
  } result_t;

  // One stage of the divide pipeline
  typedef struct packed {
    logic                           div;
    logic                           ovf;
    logic [CoordW-1:0]              w;
    logic [CoordW-1:0]              dvsr;
    logic [NumLane-1:0]             neg;
    logic [NumLane-1:0][CoordW-1:0] rem;
    logic [NumLane-1:0][QuoW-1:0]   quo;
  } div_stage_t;

  typedef struct packed {
    logic [CoordW-1:0] rem;
    logic [QuoW-1:0]   quo;
  } step_t;

  typedef struct packed {
    logic [CoordW-1:0] val;
    logic              ovf;
  } sat_t;

  // Coefficient M[row][col] from the packed register file
  function automatic logic signed [CoordW-1:0] coef(matrix_t m, int unsigned row,
                                                    int unsigned col);
    logic [CfgW-1:0] r;
    r = m[2 * row + col / 2];
    return (col % 2 == 1) ? $signed(r[CfgW-1:CoordW]) : $signed(r[CoordW-1:0]);
  endfunction

  // Floor the exact column sum to Q16.16 and clamp to 32 bits
  function automatic sat_t sat_sum(logic signed [SumW-1:0] s);
    sat_t res;
    logic [SumW-FracW-1:0] f;
    f = s[SumW-1:FracW];
    if (f[SumW-FracW-1:CoordW-1] == '0 || f[SumW-FracW-1:CoordW-1] == '1) begin
      res.val = f[CoordW-1:0];
      res.ovf = 1'b0;
    end else begin
      res.val = f[SumW-FracW-1] ? CoordMin : CoordMax;
      res.ovf = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [CoordW-1:0] mag(logic [CoordW-1:0] a);
    return a[CoordW-1] ? (~a + 1'b1) : a;
  endfunction

  // One restoring division step: bring down one dividend bit
  function automatic step_t div_step(logic [CoordW-1:0] rem, logic [QuoW-1:0] quo,
                                     logic [CoordW-1:0] dvsr);
    step_t res;
    logic [CoordW:0] t;
    logic            ge;
    t  = {rem, quo[QuoW-1]};
    ge = t >= {1'b0, dvsr};
    if (ge) begin
      t = t - {1'b0, dvsr};
    end
    res.rem = t[CoordW-1:0];
    res.quo = {quo[QuoW-2:0], ge};
    return res;
  endfunction

  // Apply the sign to a quotient magnitude and clamp to 32 bits
  function automatic sat_t sat_quo(logic [QuoW-1:0] q, logic neg);
    sat_t res;
    res.ovf = 1'b0;
    if (neg) begin
      if (q > QuoW'(CoordMin)) begin
        res.val = CoordMin;
        res.ovf = 1'b1;
      end else begin
        res.val = ~q[CoordW-1:0] + 1'b1;
      end
    end else begin
      if (q > QuoW'(CoordMax)) begin
        res.val = CoordMax;
        res.ovf = 1'b1;
      end else begin
        res.val = q[CoordW-1:0];
      end
    end
    return res;
  endfunction

endpackage

// ===== design/vtp_fifo.sv =====
module vtp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/vtp_front.sv =====
module vtp_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vtp_pkg::matrix_t                      mat_i,
  input  logic                                  push_i,
  input  logic signed [vtp_pkg::CoordW-1:0]     in_x_i,
  input  logic signed [vtp_pkg::CoordW-1:0]     in_y_i,
  input  logic signed [vtp_pkg::CoordW-1:0]     in_z_i,
  input  logic signed [vtp_pkg::CoordW-1:0]     in_w_i,
  output logic                                  full_o,
  output logic                                  mid_push_o,
  output vtp_pkg::xform_t                       mid_data_o,
  input  logic                                  mid_full_i
);

  logic                                   en;
  logic                                   v1_q, v2_q, v3_q;
  logic signed [vtp_pkg::CoordW-1:0]      pt [4];
  logic signed [vtp_pkg::ProdW-1:0]       prod_d [4][4];
  logic signed [vtp_pkg::ProdW-1:0]       prod_q [4][4];
  logic signed [vtp_pkg::PairW-1:0]       pair_d [4][2];
  logic signed [vtp_pkg::PairW-1:0]       pair_q [4][2];
  vtp_pkg::xform_t                        res_d, res_q;
  vtp_pkg::sat_t                          sat [4];

  // Hold the whole front while the queue to the back is full
  assign en     = !mid_full_i;
  assign full_o = mid_full_i;

  assign pt[0] = in_x_i;
  assign pt[1] = in_y_i;
  assign pt[2] = in_z_i;
  assign pt[3] = in_w_i;

  // Sixteen full-width products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[i][c] = pt[i] * vtp_pkg::coef(mat_i, i, c);
      end
    end
  end

  // Pairwise partial sums per column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pair_d[c][0] = vtp_pkg::PairW'(prod_q[0][c]) + vtp_pkg::PairW'(prod_q[1][c]);
      pair_d[c][1] = vtp_pkg::PairW'(prod_q[2][c]) + vtp_pkg::PairW'(prod_q[3][c]);
    end
  end

  // Column totals, floored to Q16.16 and clamped
  always_comb begin
    res_d.ovf = 1'b0;
    for (int c = 0; c < 4; c++) begin
      sat[c]     = vtp_pkg::sat_sum(vtp_pkg::SumW'(pair_q[c][0]) +
                                    vtp_pkg::SumW'(pair_q[c][1]));
      res_d.r[c] = sat[c].val;
      res_d.ovf  = res_d.ovf | sat[c].ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      pair_q <= pair_d;
      res_q  <= res_d;
    end
  end

  assign mid_push_o = v3_q && en;
  assign mid_data_o = res_q;

endmodule

// ===== design/vtp_back.sv =====
module vtp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vtp_pkg::xform_t   mid_data_i,
  input  logic              mid_empty_i,
  output logic              mid_pop_o,
  output logic              out_push_o,
  output vtp_pkg::result_t  out_data_o,
  input  logic              out_full_i
);

  localparam int unsigned N = vtp_pkg::NumStep;

  logic                 en;
  logic                 vld_q [N+1];
  vtp_pkg::div_stage_t  stg_q [N+1];
  vtp_pkg::div_stage_t  ld_d;
  vtp_pkg::sat_t        qs;

  // Hold the divide pipeline while the result queue is full
  assign en        = !out_full_i;
  assign mid_pop_o = en && !mid_empty_i;

  // Classify the point and set up magnitudes
  always_comb begin
    ld_d.w    = mid_data_i.r[3];
    ld_d.div  = mid_data_i.r[3] != '0;
    ld_d.ovf  = mid_data_i.ovf;
    ld_d.dvsr = vtp_pkg::mag(mid_data_i.r[3]);
    for (int l = 0; l < vtp_pkg::NumLane; l++) begin
      ld_d.neg[l] = mid_data_i.r[l][vtp_pkg::CoordW-1] ^ mid_data_i.r[3][vtp_pkg::CoordW-1];
      ld_d.rem[l] = '0;
      ld_d.quo[l] = ld_d.div ? {vtp_pkg::mag(mid_data_i.r[l]), {vtp_pkg::FracW{1'b0}}}
                             : {{vtp_pkg::FracW{1'b0}}, mid_data_i.r[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= !mid_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= ld_d;
    end
  end

  // One quotient bit per stage; undivided points pass untouched
  for (genvar k = 1; k <= N; k++) begin : g_step
    vtp_pkg::div_stage_t nx;
    vtp_pkg::step_t      st [vtp_pkg::NumLane];

    always_comb begin
      nx = stg_q[k-1];
      for (int l = 0; l < vtp_pkg::NumLane; l++) begin
        st[l] = vtp_pkg::div_step(stg_q[k-1].rem[l], stg_q[k-1].quo[l], stg_q[k-1].dvsr);
        if (stg_q[k-1].div) begin
          nx.rem[l] = st[l].rem;
          nx.quo[l] = st[l].quo;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[k] <= nx;
      end
    end
  end

  // Sign and clamp the quotients of divided points
  always_comb begin
    out_data_o.r[3] = stg_q[N].w;
    out_data_o.div  = stg_q[N].div;
    out_data_o.ovf  = stg_q[N].ovf;
    qs              = '0;
    for (int l = 0; l < vtp_pkg::NumLane; l++) begin
      qs = vtp_pkg::sat_quo(stg_q[N].quo[l], stg_q[N].neg[l]);
      if (stg_q[N].div) begin
        out_data_o.r[l] = qs.val;
        out_data_o.ovf  = out_data_o.ovf | qs.ovf;
      end else begin
        out_data_o.r[l] = stg_q[N].quo[l][vtp_pkg::CoordW-1:0];
      end
    end
  end

  assign out_push_o = vld_q[N] && en;

endmodule

// ===== design/vertex_transform_project_core.sv =====
// Homogeneous vertex transform with perspective divide, signed Q16.16.
// Each point (x, y, z, w) is multiplied as a row vector by the 4x4 matrix
// in the eight configuration registers, the column sums are floored and
// clamped to 32 bits, and x', y', z' are divided by w' (quotient rounded
// towards zero, clamped) unless w' is zero. One point is taken per clock
// while full is low and one result leaves per clock in steady flow; a
// point passes the three-stage multiply-and-sum front, the queue to the
// back, the divider's load stage and its 48 bit-per-stage steps, and the
// result queue on its way to the result ports. Write the matrix only
// while no point is in flight.
module vertex_transform_project_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vtp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [vtp_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic signed [vtp_pkg::CoordW-1:0]   in_x_i,
  input  logic signed [vtp_pkg::CoordW-1:0]   in_y_i,
  input  logic signed [vtp_pkg::CoordW-1:0]   in_z_i,
  input  logic signed [vtp_pkg::CoordW-1:0]   in_w_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [vtp_pkg::CoordW-1:0]   out_x_o,
  output logic signed [vtp_pkg::CoordW-1:0]   out_y_o,
  output logic signed [vtp_pkg::CoordW-1:0]   out_z_o,
  output logic signed [vtp_pkg::CoordW-1:0]   out_w_o,
  output logic                                was_divided_o,
  output logic                                overflowed_o
);

  vtp_pkg::matrix_t  mat_q;
  logic              mid_push, mid_full, mid_pop, mid_empty;
  vtp_pkg::xform_t   mid_in, mid_out;
  logic              out_push, out_full;
  vtp_pkg::result_t  out_in, out_out;

  // Matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  vtp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mat_i      (mat_q),
    .push_i     (push),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .in_z_i     (in_z_i),
    .in_w_i     (in_w_i),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_in),
    .mid_full_i (mid_full)
  );

  vtp_fifo #(
    .WIDTH ($bits(vtp_pkg::xform_t)),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  vtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_data_o  (out_in),
    .out_full_i  (out_full)
  );

  vtp_fifo #(
    .WIDTH ($bits(vtp_pkg::result_t)),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_out),
    .empty_o (empty)
  );

  assign out_x_o       = out_out.r[0];
  assign out_y_o       = out_out.r[1];
  assign out_z_o       = out_out.r[2];
  assign out_w_o       = out_out.r[3];
  assign was_divided_o = out_out.div;
  assign overflowed_o  = out_out.ovf;

endmodule

// ===== tb/vertex_transform_project_checker.sv =====
module vertex_transform_project_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vtp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [vtp_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              push,
  input  logic                              full,
  input  logic signed [vtp_pkg::CoordW-1:0] in_x_i,
  input  logic signed [vtp_pkg::CoordW-1:0] in_y_i,
  input  logic signed [vtp_pkg::CoordW-1:0] in_z_i,
  input  logic signed [vtp_pkg::CoordW-1:0] in_w_i,
  input  logic                              empty,
  input  logic                              pop,
  input  logic signed [vtp_pkg::CoordW-1:0] out_x_i,
  input  logic signed [vtp_pkg::CoordW-1:0] out_y_i,
  input  logic signed [vtp_pkg::CoordW-1:0] out_z_i,
  input  logic signed [vtp_pkg::CoordW-1:0] out_w_i,
  input  logic                              was_divided_i,
  input  logic                              overflowed_i,
  output int                                errors_o,
  output int                                pending_o
);

  typedef struct {
    logic signed [31:0] crd [4];
    logic               divided;
    logic               ovf;
  } projected_t;

  logic [vtp_pkg::CfgW-1:0] matrix_q [vtp_pkg::NumRegs];
  projected_t               projected_q [$];
  int                       errors;

  assign errors_o  = errors;
  assign pending_o = projected_q.size();

  // Clamp a wide value to the signed 32-bit range, flagging overflow
  function automatic logic signed [31:0] clamp32(logic signed [65:0] v, inout logic ovf);
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Transform one point by the matrix copy and apply the perspective divide
  function automatic projected_t project(logic signed [31:0] pnt [4]);
    projected_t         res;
    logic signed [65:0] acc;
    logic signed [31:0] cf;
    logic [63:0]        rg;
    logic signed [63:0] num;
    logic signed [63:0] den;
    res.ovf     = 1'b0;
    res.divided = 1'b0;
    for (int col = 0; col < 4; col++) begin
      acc = '0;
      for (int row = 0; row < 4; row++) begin
        rg  = matrix_q[2 * row + col / 2];
        cf  = (col % 2 == 1) ? rg[63:32] : rg[31:0];
        acc = acc + pnt[row] * cf;
      end
      res.crd[col] = clamp32(acc >>> 16, res.ovf);
    end
    if (res.crd[3] != 0) begin
      res.divided = 1'b1;
      den = res.crd[3];
      for (int i = 0; i < 3; i++) begin
        num = res.crd[i];
        num = num * 64'sd65536;
        res.crd[i] = clamp32(66'(num / den), res.ovf);
      end
    end
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    foreach (matrix_q[i]) matrix_q[i] = '0;
  end

  // Track the matrix, predict each accepted point, compare each popped request
  always @(posedge clk_i) begin
    logic signed [31:0] pnt [4];
    projected_t         want;
    if (rst_ni) begin
      if (cfg_we_i) matrix_q[cfg_idx_i] = cfg_data_i;
      if (push && !full) begin
        pnt[0] = in_x_i;
        pnt[1] = in_y_i;
        pnt[2] = in_z_i;
        pnt[3] = in_w_i;
        projected_q.push_back(project(pnt));
      end
      if (pop && !empty) begin
        if (projected_q.size() == 0) begin
          report("unexpected request", out_x_i, '0);
        end else begin
          want = projected_q.pop_front();
          if (out_x_i !== want.crd[0]) report("out_x", out_x_i, want.crd[0]);
          if (out_y_i !== want.crd[1]) report("out_y", out_y_i, want.crd[1]);
          if (out_z_i !== want.crd[2]) report("out_z", out_z_i, want.crd[2]);
          if (out_w_i !== want.crd[3]) report("out_w", out_w_i, want.crd[3]);
          if (was_divided_i !== want.divided)
            report("was_divided", 32'(was_divided_i), 32'(want.divided));
          if (overflowed_i !== want.ovf)
            report("overflowed", 32'(overflowed_i), 32'(want.ovf));
        end
      end
    end
  end

endmodule

// ===== tb/vertex_transform_project_core_tb.sv =====
module vertex_transform_project_core_tb;

  localparam logic [31:0] One    = 32'h0001_0000;
  localparam logic [31:0] NegOne = 32'hFFFF_0000;
  localparam logic [31:0] SMax   = 32'h7FFF_FFFF;
  localparam logic [31:0] SMin   = 32'h8000_0000;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [vtp_pkg::CfgIdxW-1:0]       cfg_idx;
  logic [vtp_pkg::CfgW-1:0]          cfg_data;
  logic                              push;
  logic                              full;
  logic signed [vtp_pkg::CoordW-1:0] in_x, in_y, in_z, in_w;
  logic                              empty;
  logic                              pop;
  logic signed [vtp_pkg::CoordW-1:0] out_x, out_y, out_z, out_w;
  logic                              was_divided, overflowed;
  int                                errors;
  int                                pending;
  int                                burst_left;
  int                                pop_mode;
  int                                pop_cycle;
  logic [31:0]                       coefs [16];

  vertex_transform_project_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .in_x_i       (in_x),
    .in_y_i       (in_y),
    .in_z_i       (in_z),
    .in_w_i       (in_w),
    .empty        (empty),
    .pop          (pop),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_z_o      (out_z),
    .out_w_o      (out_w),
    .was_divided_o(was_divided),
    .overflowed_o (overflowed)
  );

  vertex_transform_project_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .in_x_i       (in_x),
    .in_y_i       (in_y),
    .in_z_i       (in_z),
    .in_w_i       (in_w),
    .empty        (empty),
    .pop          (pop),
    .out_x_i      (out_x),
    .out_y_i      (out_y),
    .out_z_i      (out_z),
    .out_w_i      (out_w),
    .was_divided_i(was_divided),
    .overflowed_i (overflowed),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result side in pop modes that are picked at random
  always @(negedge clk) begin
    pop_cycle++;
    if (pop_cycle % 200 == 0) pop_mode = $urandom_range(0, 3);
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= $urandom_range(0, 1);
      2: pop <= ($urandom_range(0, 9) == 0);
      default: pop <= ((pop_cycle / 8) % 2 == 0);
    endcase
  end

  // Coordinate with a bias towards small magnitudes and special values
  function automatic logic [31:0] pick_coord();
    logic [31:0] specials [7];
    specials = '{32'h0, 32'h1, 32'hFFFF_FFFF, SMax, SMin, One, NegOne};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      4, 5, 6:    return $urandom;
      7:          return specials[$urandom_range(0, 6)];
      default:    return $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
    endcase
  endfunction

  // Offer one point; hold push high across a burst
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    push <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    in_w <= w;
    do @(posedge clk); while (full);
    @(negedge clk);
    burst_left--;
  endtask

  // Stop sending and wait until every expected request has left the block
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  // Write the whole matrix from coefs[row*4 + col]
  task automatic load_matrix();
    for (int i = 0; i < vtp_pkg::NumRegs; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= vtp_pkg::CfgIdxW'(i);
      cfg_data <= {coefs[2 * i + 1], coefs[2 * i]};
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_points(int count);
    for (int n = 0; n < count; n++)
      send_point(pick_coord(), pick_coord(), pick_coord(),
                 ($urandom_range(0, 4) == 0) ? 32'h0 : pick_coord());
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    push       = 1'b0;
    pop        = 1'b0;
    in_x       = '0;
    in_y       = '0;
    in_z       = '0;
    in_w       = '0;
    burst_left = 0;
    pop_mode   = 0;
    pop_cycle  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Matrix still zero after reset: every w' is zero
    send_point(SMax, SMin, One, NegOne);
    random_points(20);
    drain();

    // Identity: w' = w, so the divide, tiny-w quotient overflow and zero w show up
    foreach (coefs[i]) coefs[i] = (i % 5 == 0) ? One : 32'h0;
    load_matrix();
    send_point(One, One, One, One);
    send_point(SMax, SMin, 32'h0, 32'h1);
    send_point(SMin, SMax, NegOne, 32'hFFFF_FFFF);
    send_point(SMin, 32'h3_0000, 32'h0, NegOne);
    send_point(SMax, SMin, 32'h1234_5678, 32'h0);
    send_point(32'h2_0000, 32'hFFFE_0000, 32'h5_0000, 32'h2_0000);
    send_point(SMax, SMax, SMax, SMax);
    send_point(SMin, SMin, SMin, SMin);
    random_points(250);
    drain();

    // Largest coefficients: column sums saturate both ways
    foreach (coefs[i]) coefs[i] = SMax;
    load_matrix();
    send_point(SMax, SMax, SMax, SMax);
    send_point(SMin, SMin, SMin, SMin);
    send_point(32'h0, 32'h0, 32'h0, 32'h1);
    random_points(150);
    drain();
    foreach (coefs[i]) coefs[i] = SMin;
    load_matrix();
    send_point(SMin, SMin, SMin, SMin);
    send_point(SMax, SMin, SMax, SMin);
    random_points(150);
    drain();

    // Perspective-like matrix with small random terms
    foreach (coefs[i]) coefs[i] = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
    coefs[11] = One;
    coefs[15] = 32'h0;
    load_matrix();
    random_points(300);
    // Let the pipe run dry once in mid-stream
    drain();
    random_points(200);
    drain();

    // Full-range random matrices
    for (int ph = 0; ph < 3; ph++) begin
      foreach (coefs[i])
        coefs[i] = ($urandom_range(0, 1) == 0) ? $urandom
                                                : $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      load_matrix();
      random_points(230);
      drain();
    end

    if (errors == 0) begin
      $display("vertex_transform_project_core_tb: clean");
    end else begin
      $display("vertex_transform_project_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("vertex_transform_project_core_tb: errors");
    $finish;
  end

endmodule
